// File: hw/rtl/lr_pkg.sv
// Line rasterizer package: widths, kind codes and the structs passed between stages.
// No dependencies; every other file of the rasterizer imports it.
`default_nettype none

package lr_pkg;

   localparam int COORD_BITS  = 10;
   localparam int DEC_W       = COORD_BITS + 3;
   localparam int COLOR_W     = 8;
   localparam int WIDTH_W     = 11;
   localparam int IDX_W       = 20;
   localparam int WIDTH_RESET = 1024;
   localparam int SUM_W       = COORD_BITS + WIDTH_W + 1;

   typedef logic [COORD_BITS-1:0]   coord_type;
   typedef logic [COLOR_W-1:0]      color_type;
   typedef logic signed [DEC_W-1:0] dec_type;

   typedef enum logic [0:0] {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   // Input item as held in the input register.
   typedef struct packed {
      kind_type  kind;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      color_type red;
      color_type green;
      color_type blue;
   } item_type;

   // Line state derived from a start item.
   typedef struct packed {
      logic      swapped;
      logic      minor_up;
      logic      busy;
      coord_type major_pos;
      coord_type major_stop;
      coord_type minor_pos;
      dec_type   decision;
      dec_type   dec_up;
      dec_type   dec_flat;
   } setup_type;

   // Pixel on its way to the index stage.
   typedef struct packed {
      coord_type x;
      coord_type y;
      color_type red;
      color_type green;
      color_type blue;
      logic      last;
   } pixel_type;

endpackage

`default_nettype wire

// File: hw/rtl/lr_if.sv
// Valid/ready channel interfaces of the line rasterizer: request and response.
// Depends on lr_pkg for field widths.
`default_nettype none

interface lr_req_if import lr_pkg::*; ();
   logic      valid;
   logic      ready;
   kind_type  kind;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   color_type red_in;
   color_type green_in;
   color_type blue_in;

   modport source (output valid, kind, start_x, start_y, end_x, end_y,
                   red_in, green_in, blue_in, input ready);
   modport sink   (input valid, kind, start_x, start_y, end_x, end_y,
                   red_in, green_in, blue_in, output ready);
endinterface

interface lr_rsp_if import lr_pkg::*; ();
   logic             valid;
   logic             ready;
   coord_type        pixel_x;
   coord_type        pixel_y;
   logic [IDX_W-1:0] pixel_index;
   color_type        red_out;
   color_type        green_out;
   color_type        blue_out;
   logic             last;

   modport source (output valid, pixel_x, pixel_y, pixel_index, red_out, green_out,
                   blue_out, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_index, red_out, green_out,
                   blue_out, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lr_setup.sv
// Line setup: axis swap, endpoint ordering, spans and decision terms of a start item.
// Combinational; depends on lr_pkg.
`default_nettype none

module lr_setup import lr_pkg::*; (
   input  item_type  item,
   output setup_type setup
);

   coord_type adx, ady;
   coord_type amaj, amin, bmaj, bmin, smin, emin;
   coord_type major_span, minor_span;
   logic      swapped, minor_up;
   dec_type   flat2, major2;

   always_comb begin
      adx = (item.start_x > item.end_x) ? item.start_x - item.end_x
                                        : item.end_x - item.start_x;
      ady = (item.start_y > item.end_y) ? item.start_y - item.end_y
                                        : item.end_y - item.start_y;
      swapped = ady > adx;
      if (swapped) begin
         amaj = item.start_y; amin = item.start_x;
         bmaj = item.end_y;   bmin = item.end_x;
      end else begin
         amaj = item.start_x; amin = item.start_y;
         bmaj = item.end_x;   bmin = item.end_y;
      end

      // order so the major coordinate rises
      if (amaj <= bmaj) begin
         setup.major_pos  = amaj;
         setup.major_stop = bmaj;
         smin = amin;
         emin = bmin;
      end else begin
         setup.major_pos  = bmaj;
         setup.major_stop = amaj;
         smin = bmin;
         emin = amin;
      end

      minor_up   = emin >= smin;
      major_span = setup.major_stop - setup.major_pos;
      minor_span = minor_up ? emin - smin : smin - emin;

      flat2  = dec_type'({2'b00, minor_span, 1'b0});
      major2 = dec_type'({2'b00, major_span, 1'b0});

      setup.swapped   = swapped;
      setup.minor_up  = minor_up;
      setup.minor_pos = smin;
      setup.busy      = setup.major_pos != setup.major_stop;
      setup.decision  = flat2 - dec_type'({3'b000, major_span});
      setup.dec_flat  = flat2;
      setup.dec_up    = flat2 - major2;
   end

endmodule

`default_nettype wire

// File: hw/rtl/lr_walker.sv
// Line walker: holds the running line state, advances one major-axis pixel per step
// and registers the pixel. Depends on lr_pkg and lr_setup.
`default_nettype none

module lr_walker import lr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      item_valid,
   output logic      item_ready,
   input  item_type  item,
   output logic      pix_valid,
   input  logic      pix_ready,
   output pixel_type pix
);

   setup_type setup;

   logic      busy_ff, busy_in;
   logic      swapped_ff, swapped_in;
   logic      minor_up_ff, minor_up_in;
   coord_type major_pos_ff, major_pos_in;
   coord_type major_stop_ff, major_stop_in;
   coord_type minor_pos_ff, minor_pos_in;
   dec_type   dec_ff, dec_in;
   dec_type   dec_up_ff, dec_up_in;
   dec_type   dec_flat_ff, dec_flat_in;
   color_type red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic      pix_valid_ff, pix_valid_in;
   pixel_type pix_ff, pix_in;
   logic      advance;

   lr_setup u_setup (
      .item  (item),
      .setup (setup)
   );

   assign advance    = !pix_valid_ff || pix_ready;
   assign item_ready = advance;
   assign pix_valid  = pix_valid_ff;
   assign pix        = pix_ff;

   always_comb begin
      busy_in       = busy_ff;
      swapped_in    = swapped_ff;
      minor_up_in   = minor_up_ff;
      major_pos_in  = major_pos_ff;
      major_stop_in = major_stop_ff;
      minor_pos_in  = minor_pos_ff;
      dec_in        = dec_ff;
      dec_up_in     = dec_up_ff;
      dec_flat_in   = dec_flat_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      pix_valid_in  = pix_valid_ff;
      pix_in        = pix_ff;

      if (advance) begin
         pix_valid_in = 1'b0;
         if (item_valid) begin
            case (item.kind)
               KIND_START: begin
                  busy_in       = setup.busy;
                  swapped_in    = setup.swapped;
                  minor_up_in   = setup.minor_up;
                  major_pos_in  = setup.major_pos;
                  major_stop_in = setup.major_stop;
                  minor_pos_in  = setup.minor_pos;
                  dec_in        = setup.decision;
                  dec_up_in     = setup.dec_up;
                  dec_flat_in   = setup.dec_flat;
                  red_in        = item.red;
                  green_in      = item.green;
                  blue_in       = item.blue;
                  pix_valid_in  = 1'b1;
               end
               KIND_STEP: begin
                  // drop steps that arrive with no line running
                  if (busy_ff) begin
                     major_pos_in = major_pos_ff + coord_type'(1);
                     if (!dec_ff[DEC_W-1]) begin
                        minor_pos_in = minor_up_ff ? minor_pos_ff + coord_type'(1)
                                                   : minor_pos_ff - coord_type'(1);
                        dec_in       = dec_ff + dec_up_ff;
                     end else begin
                        dec_in       = dec_ff + dec_flat_ff;
                     end
                     busy_in      = major_pos_in != major_stop_ff;
                     pix_valid_in = 1'b1;
                  end
               end
               default: begin
                  pix_valid_in = 1'b0;
               end
            endcase
            pix_in.x     = swapped_in ? minor_pos_in : major_pos_in;
            pix_in.y     = swapped_in ? major_pos_in : minor_pos_in;
            pix_in.red   = red_in;
            pix_in.green = green_in;
            pix_in.blue  = blue_in;
            pix_in.last  = !busy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pix_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pix_valid_ff <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      swapped_ff    <= swapped_in;
      minor_up_ff   <= minor_up_in;
      major_pos_ff  <= major_pos_in;
      major_stop_ff <= major_stop_in;
      minor_pos_ff  <= minor_pos_in;
      dec_ff        <= dec_in;
      dec_up_ff     <= dec_up_in;
      dec_flat_ff   <= dec_flat_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      pix_ff        <= pix_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/lr_index.sv
// Index stage: forms the row-major pixel index and holds the response register.
// Depends on lr_pkg and the lr_rsp_if interface.
`default_nettype none

module lr_index import lr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [WIDTH_W-1:0] line_width,
   input  logic               pix_valid,
   output logic               pix_ready,
   input  pixel_type          pix,
   lr_rsp_if.source           rsp
);

   logic             rsp_valid_ff, rsp_valid_in;
   pixel_type        out_ff, out_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] sum;
   logic             advance;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign pix_ready = advance;

   always_comb begin
      sum          = SUM_W'(pix.y) * SUM_W'(line_width) + SUM_W'(pix.x);
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      idx_in       = idx_ff;
      if (advance) begin
         rsp_valid_in = pix_valid;
         out_in       = pix;
         idx_in       = IDX_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      idx_ff <= idx_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_x     = out_ff.x;
   assign rsp.pixel_y     = out_ff.y;
   assign rsp.pixel_index = idx_ff;
   assign rsp.red_out     = out_ff.red;
   assign rsp.green_out   = out_ff.green;
   assign rsp.blue_out    = out_ff.blue;
   assign rsp.last        = out_ff.last;

endmodule

`default_nettype wire

// File: hw/rtl/line_rasterizer.sv
// Bresenham line rasterizer, top level. A request transaction passes the input register,
// the walker pixel register and the index register, in that order, on its way to a response.
// Throughput: one request transaction per cycle while the response channel takes every
// response; each start or running step yields one pixel. Reset (synchronous, active high)
// clears all valid flags and the line-running flag and sets line_width to 1024.
`default_nettype none

module line_rasterizer import lr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [WIDTH_W-1:0] csr_wr_data,
   lr_req_if.sink             req_bus,
   lr_rsp_if.source           rsp_bus
);

   // Frame width register, the row stride of the pixel index.
   logic [WIDTH_W-1:0] width_ff, width_in;

   // Input register: holds one request transaction until the walker takes it.
   logic      in_valid_ff, in_valid_in;
   item_type  in_ff, in_in;
   logic      walk_ready;

   // Walker to index stage.
   logic      pix_valid, pix_ready;
   pixel_type pix;

   always_comb begin
      width_in = csr_wr_en ? csr_wr_data : width_ff;
   end

   // Accept whenever the register is empty or drains into the walker this cycle.
   assign req_bus.ready = !in_valid_ff || walk_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_bus.ready) begin
         in_valid_in   = req_bus.valid;
         in_in.kind    = req_bus.kind;
         in_in.start_x = req_bus.start_x;
         in_in.start_y = req_bus.start_y;
         in_in.end_x   = req_bus.end_x;
         in_in.end_y   = req_bus.end_y;
         in_in.red     = req_bus.red_in;
         in_in.green   = req_bus.green_in;
         in_in.blue    = req_bus.blue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_W'(WIDTH_RESET);
         in_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   // Walker: line setup on start, one major-axis advance on step, pixel register.
   lr_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_ready (walk_ready),
      .item       (in_ff),
      .pix_valid  (pix_valid),
      .pix_ready  (pix_ready),
      .pix        (pix)
   );

   // Index stage: y * line_width + x, wrapped to the index width, and response register.
   lr_index u_index (
      .clock      (clock),
      .reset      (reset),
      .line_width (width_ff),
      .pix_valid  (pix_valid),
      .pix_ready  (pix_ready),
      .pix        (pix),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

// File: sim/tb_raster_pkg.sv
// Scoreboard for the line rasterizer testbench: a Bresenham line walker and the pixels due.
// Depends on lr_pkg for the item layout, field widths and the kind codes.
`default_nettype none

package tb_raster_pkg;
   import lr_pkg::*;

   typedef struct {
      coord_type        x;
      coord_type        y;
      logic [IDX_W-1:0] index;
      color_type        red;
      color_type        green;
      color_type        blue;
      logic             last;
   } pixel_rec_type;

   class raster_scoreboard;
      logic [WIDTH_W-1:0] line_width;
      logic               busy;
      logic               swapped;
      logic               minor_up;
      coord_type          major_pos;
      coord_type          major_stop;
      coord_type          minor_pos;
      coord_type          major_span;
      coord_type          minor_span;
      dec_type            decision;
      color_type          red;
      color_type          green;
      color_type          blue;
      pixel_rec_type      pixels_due[$];
      int unsigned        failures;
      int unsigned        lines_started;
      int unsigned        pixels_checked;

      function new();
         line_width     = WIDTH_W'(WIDTH_RESET);
         busy           = 1'b0;
         swapped        = 1'b0;
         minor_up       = 1'b0;
         major_pos      = '0;
         major_stop     = '0;
         minor_pos      = '0;
         major_span     = '0;
         minor_span     = '0;
         decision       = '0;
         red            = '0;
         green          = '0;
         blue           = '0;
         failures       = 0;
         lines_started  = 0;
         pixels_checked = 0;
      endfunction

      function void set_line_width(logic [WIDTH_W-1:0] w);
         line_width = w;
      endfunction

      function int unsigned pending();
         return pixels_due.size();
      endfunction

      // Queue the pixel at the current walker position, row-major index wrapped to 20 bits.
      function void push_pixel();
         pixel_rec_type p;
         logic [31:0]   wide;
         p.x     = swapped ? minor_pos : major_pos;
         p.y     = swapped ? major_pos : minor_pos;
         wide    = 32'(p.y) * 32'(line_width) + 32'(p.x);
         p.index = wide[IDX_W-1:0];
         p.red   = red;
         p.green = green;
         p.blue  = blue;
         p.last  = !busy;
         pixels_due.push_back(p);
      endfunction

      function void note_request(item_type it);
         coord_type dx;
         coord_type dy;
         coord_type a_maj;
         coord_type a_min;
         coord_type b_maj;
         coord_type b_min;
         coord_type end_minor;
         if (it.kind == KIND_START) begin
            dx      = (it.start_x > it.end_x) ? it.start_x - it.end_x : it.end_x - it.start_x;
            dy      = (it.start_y > it.end_y) ? it.start_y - it.end_y : it.end_y - it.start_y;
            swapped = dy > dx;
            a_maj   = swapped ? it.start_y : it.start_x;
            a_min   = swapped ? it.start_x : it.start_y;
            b_maj   = swapped ? it.end_y : it.end_x;
            b_min   = swapped ? it.end_x : it.end_y;
            // order the endpoints so the major coordinate rises
            if (a_maj <= b_maj) begin
               major_pos  = a_maj;
               minor_pos  = a_min;
               major_stop = b_maj;
               end_minor  = b_min;
            end else begin
               major_pos  = b_maj;
               minor_pos  = b_min;
               major_stop = a_maj;
               end_minor  = a_min;
            end
            minor_up   = end_minor >= minor_pos;
            major_span = major_stop - major_pos;
            minor_span = minor_up ? end_minor - minor_pos : minor_pos - end_minor;
            decision   = dec_type'(2 * int'(minor_span) - int'(major_span));
            red        = it.red;
            green      = it.green;
            blue       = it.blue;
            busy       = major_pos != major_stop;
            lines_started++;
            push_pixel();
         end else if (busy) begin
            major_pos = major_pos + coord_type'(1);
            if (!decision[DEC_W-1]) begin
               minor_pos = minor_up ? minor_pos + coord_type'(1) : minor_pos - coord_type'(1);
               decision  = dec_type'(int'(decision) + 2 * int'(minor_span)
                                     - 2 * int'(major_span));
            end else begin
               decision  = dec_type'(int'(decision) + 2 * int'(minor_span));
            end
            busy = major_pos != major_stop;
            push_pixel();
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_pixel(pixel_rec_type got);
         pixel_rec_type want;
         if (pixels_due.size() == 0) begin
            $error("pixel (%0d,%0d) arrived with no pixel due", got.x, got.y);
            failures++;
            return;
         end
         want = pixels_due.pop_front();
         pixels_checked++;
         compare_field("pixel_x", 32'(want.x), 32'(got.x));
         compare_field("pixel_y", 32'(want.y), 32'(got.y));
         compare_field("pixel_index", 32'(want.index), 32'(got.index));
         compare_field("red_out", 32'(want.red), 32'(got.red));
         compare_field("green_out", 32'(want.green), 32'(got.green));
         compare_field("blue_out", 32'(want.blue), 32'(got.blue));
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

endpackage

`default_nettype wire

// File: sim/tb_line_rasterizer.sv
// Top-level testbench of line_rasterizer: drives start and step transactions, checks every
// pixel against the scoreboard walker. Depends on lr_pkg, lr_if and tb_raster_pkg.
`default_nettype none

module tb_line_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   import lr_pkg::*;
   import tb_raster_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 7;
   // Spare drain cycles, beyond the last due pixel, cover steps that yield nothing.
   localparam int DRAIN_CYCLES    = 6;
   localparam int RSP_HOLD_CYCLES = 120;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_PIXELS    = 80;
   localparam int PHASE_COUNT     = 6;
   localparam int COORD_MAX       = (1 << COORD_BITS) - 1;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [WIDTH_W-1:0] csr_wr_data;

   lr_req_if req_bus ();
   lr_rsp_if rsp_bus ();

   line_rasterizer u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   raster_scoreboard sb = new();

   // Idle odds in percent per offered request or receiver turn, set phase by phase.
   int unsigned req_gap_pct  = 0;
   int unsigned rsp_gap_pct  = 0;
   // Raised by the stimulus to make the receiver hold off for one long stretch.
   bit          rsp_hold_req = 1'b0;
   int unsigned widths_used  = 0;
   int unsigned quiet_cycles = 0;

   pixel_rec_type seen_pixel;
   item_type      seen_item;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Monitor: sample everything at the rising edge, before any of this edge's updates land.
   // Check the response first: a request accepted at the same edge cannot be its source.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            sb.set_line_width(csr_wr_data);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_pixel.x     = rsp_bus.pixel_x;
            seen_pixel.y     = rsp_bus.pixel_y;
            seen_pixel.index = rsp_bus.pixel_index;
            seen_pixel.red   = rsp_bus.red_out;
            seen_pixel.green = rsp_bus.green_out;
            seen_pixel.blue  = rsp_bus.blue_out;
            seen_pixel.last  = rsp_bus.last;
            sb.check_pixel(seen_pixel);
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_item.kind    = req_bus.kind;
            seen_item.start_x = req_bus.start_x;
            seen_item.start_y = req_bus.start_y;
            seen_item.end_x   = req_bus.end_x;
            seen_item.end_y   = req_bus.end_y;
            seen_item.red     = req_bus.red_in;
            seen_item.green   = req_bus.green_in;
            seen_item.blue    = req_bus.blue_in;
            sb.note_request(seen_item);
         end
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: ready high by default, random stall bursts, and on request one long hold-off
   // counted here so the walker backs up and stalls the request channel.
   // ---------------------------------------------------------------------------------------
   initial begin
      int unsigned held;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_bus.ready <= 1'b0;
            held = 0;
            while (held < RSP_HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
            rsp_hold_req = 1'b0;
         end else if (rsp_gap_pct != 0 && $urandom_range(0, 99) < rsp_gap_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Fill every field at random; step transactions carry junk the block must ignore.
   function automatic item_type random_item(kind_type k);
      item_type it;
      it.kind    = k;
      it.start_x = coord_type'($urandom);
      it.start_y = coord_type'($urandom);
      it.end_x   = coord_type'($urandom);
      it.end_y   = coord_type'($urandom);
      it.red     = color_type'($urandom);
      it.green   = color_type'($urandom);
      it.blue    = color_type'($urandom);
      return it;
   endfunction

   // Pick a coordinate within reach of c, clamped to the screen.
   function automatic coord_type near(coord_type c, int reach);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * reach)) - reach;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return coord_type'(v);
   endfunction

   // Mostly short lines, some medium, a rare full-screen one; some start on a screen edge.
   function automatic item_type random_start();
      item_type    it;
      int unsigned roll;
      int          reach;
      it    = random_item(KIND_START);
      roll  = $urandom_range(0, 99);
      reach = (roll < 78) ? 12 : (roll < 98) ? 80 : COORD_MAX;
      if ($urandom_range(0, 9) == 0) it.start_x = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 9) == 0) it.start_y = $urandom_range(0, 1) ? '1 : '0;
      it.end_x = near(it.start_x, reach);
      it.end_y = near(it.start_y, reach);
      return it;
   endfunction

   // Number of steps that complete a line: the longer of the two axis distances.
   function automatic int unsigned line_span(item_type it);
      int dx;
      int dy;
      dx = int'(it.start_x) - int'(it.end_x);
      dy = int'(it.start_y) - int'(it.end_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return (dx > dy) ? dx : dy;
   endfunction

   // Present one transaction and hold it until accepted. Valid stays high on return, so a
   // back-to-back caller just overwrites the payload in the same step.
   task automatic send_item(input item_type it);
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= it.kind;
      req_bus.start_x  <= it.start_x;
      req_bus.start_y  <= it.start_y;
      req_bus.end_x    <= it.end_x;
      req_bus.end_y    <= it.end_y;
      req_bus.red_in   <= it.red;
      req_bus.green_in <= it.green;
      req_bus.blue_in  <= it.blue;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Optionally drop valid for a random burst, then send.
   task automatic offer(input item_type it);
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      send_item(it);
   endtask

   task automatic start_line(input int ax, input int ay, input int bx, input int by,
                             input int r, input int g, input int b);
      item_type it;
      it.kind    = KIND_START;
      it.start_x = coord_type'(ax);
      it.start_y = coord_type'(ay);
      it.end_x   = coord_type'(bx);
      it.end_y   = coord_type'(by);
      it.red     = color_type'(r);
      it.green   = color_type'(g);
      it.blue    = color_type'(b);
      offer(it);
   endtask

   task automatic step_line(input int unsigned n);
      repeat (n) offer(random_item(KIND_STEP));
   endtask

   // Drop valid and wait until every due pixel is back; the monitor has seen the last
   // accepted request before the pending count is first checked.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_line_width(input logic [WIDTH_W-1:0] w);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      widths_used++;
   endtask

   // Random lines until about `target` pixels are due: mostly whole lines, some cut short
   // by the next start, some followed by steps that land on an idle walker.
   task automatic run_random_lines(input int unsigned target);
      item_type    it;
      int unsigned made;
      int unsigned span;
      int unsigned steps;
      int unsigned roll;
      made = 0;
      while (made < target) begin
         it   = random_start();
         span = line_span(it);
         roll = $urandom_range(0, 99);
         if (roll < 80) steps = span;
         else if (roll < 90) steps = (span == 0) ? 0 : $urandom_range(0, span - 1);
         else steps = span + $urandom_range(1, 3);
         offer(it);
         step_line(steps);
         made += 1 + ((steps < span) ? steps : span);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin
      int unsigned        phase;
      logic [WIDTH_W-1:0] w;

      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.kind     <= KIND_START;
      req_bus.start_x  <= '0;
      req_bus.start_y  <= '0;
      req_bus.end_x    <= '0;
      req_bus.end_y    <= '0;
      req_bus.red_in   <= '0;
      req_bus.green_in <= '0;
      req_bus.blue_in  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset frame width, light gaps on the request side only.
      req_gap_pct = 20;
      step_line(1);                                        // step on an idle walker
      start_line(0, 0, 0, 0, 8'h00, 8'h00, 8'h00);         // single point at the origin
      step_line(1);                                        // walker stays idle after it
      start_line(1023, 1023, 1023, 1023, 8'hff, 8'hff, 8'hff);
      start_line(1023, 5, 1020, 5, 8'hff, 8'h00, 8'h00);   // horizontal, given right to left
      step_line(3);
      start_line(7, 1023, 7, 1019, 8'h00, 8'hff, 8'h00);   // vertical, given bottom up
      step_line(4);
      start_line(0, 1023, 3, 1015, 8'h00, 8'h00, 8'hff);   // steep, minor axis falling
      step_line(2);
      start_line(1023, 0, 0, 1023, 8'h5a, 8'ha5, 8'h3c);   // full diagonal, then drop it
      step_line(2);
      start_line(10, 20, 14, 22, 8'h11, 8'h22, 8'h33);     // shallow, one step past the end
      step_line(5);

      // Random phases: each sets a frame width while idle, then runs random lines.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               w = 11'd1;    req_gap_pct = 25; rsp_gap_pct = 25;
            end
            1: begin
               w = 11'd2047; req_gap_pct = 0;  rsp_gap_pct = 30;
            end
            2: begin
               w = 11'd0;    req_gap_pct = 30; rsp_gap_pct = 0;
            end
            3: begin
               w = 11'd1023; req_gap_pct = 10; rsp_gap_pct = 10;
            end
            4: begin
               w = 11'd640;  req_gap_pct = 40; rsp_gap_pct = 40;
            end
            default: begin
               // final stretch runs flat out on both sides
               w = WIDTH_W'($urandom_range(1, WIDTH_RESET));
               req_gap_pct = 0;
               rsp_gap_pct = 0;
            end
         endcase
         write_line_width(w);
         if (phase == 3) begin
            // Hold the receiver while a long line streams in back to back.
            req_gap_pct  = 0;
            rsp_hold_req = 1'b1;
            start_line(100, 200, 160, 230, 8'h80, 8'h40, 8'h20);
            step_line(60);
            req_gap_pct  = 10;
         end
         run_random_lines(PHASE_PIXELS);
      end

      drain();
      $display("Covered %0d lines and %0d checked pixels over %0d frame widths,",
               sb.lines_started, sb.pixels_checked, widths_used + 1);
      $display("with idle steps, dropped lines, random gaps and one long receiver hold.");
      if (sb.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
